@@ sv/ltc_pkg.sv @@
package ltc_pkg;

  localparam logic [1:0] STATUS_HIT     = 2'd0;
  localparam logic [1:0] STATUS_MISS    = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam int SLOTS = 1024;
  localparam int KEY_BITS = 24;
  localparam int NUM_TABLES = 3;
  localparam int LIMIT_BITS = 11;
  localparam int CNT_BITS = 11;
  localparam int STAMP_BITS = 64;
  localparam logic [10:0] LIMIT_RESET = 11'd1000;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_SET_K,
    CMD_EVICT_SCAN,
    CMD_EVICT_KILL,
    CMD_FREE_START,
    CMD_FREE_SCAN,
    CMD_INSERT,
    CMD_HIT,
    CMD_INVALID
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } ltc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic need_evict;
    logic evict_more;
    logic invalid_target;
    logic clearing;
  } ltc_status_t;

endpackage

@@ sv/ltc_ctrl.sv @@
module ltc_ctrl
  import ltc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic        out_valid,
  input  logic        out_fire,
  input  ltc_status_t st,
  output logic        in_stall,
  output ltc_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_ESCAN  = 4'd3;
  localparam logic [3:0] S_EKILL  = 4'd4;
  localparam logic [3:0] S_FSCAN  = 4'd5;
  localparam logic [3:0] S_INSERT = 4'd6;
  localparam logic [3:0] S_HIT    = 4'd7;
  localparam logic [3:0] S_START  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE) || st.clearing || (out_valid && !out_fire);

  always_comb begin
    state_next = state;
    cmd.op = CMD_IDLE;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op = CMD_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        if (st.invalid_target) begin
          cmd.op = CMD_INVALID;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = CMD_SCAN;
        if (st.scan_done) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (st.hit) begin
          state_next = S_HIT;
        end else if (st.need_evict) begin
          cmd.op = CMD_SET_K;
          state_next = S_ESCAN;
        end else begin
          cmd.op = CMD_FREE_START;
          state_next = S_FSCAN;
        end
      end
      S_HIT: begin
        cmd.op = CMD_HIT;
        state_next = S_IDLE;
      end
      S_ESCAN: begin
        if (!st.evict_more) begin
          state_next = S_FSCAN;
        end else begin
          cmd.op = CMD_EVICT_SCAN;
          if (st.scan_done) begin
            state_next = S_EKILL;
          end
        end
      end
      S_EKILL: begin
        cmd.op = CMD_EVICT_KILL;
        state_next = S_ESCAN;
      end
      S_FSCAN: begin
        cmd.op = CMD_FREE_SCAN;
        if (st.scan_done) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.op = CMD_INSERT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/ltc_datapath.sv @@
module ltc_datapath
  import ltc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ltc_cmd_t          cmd,
  input  logic [23:0]       key,
  input  logic [1:0]        target,
  input  logic              entry_limit_we,
  input  logic [10:0]       entry_limit,
  input  logic              out_fire,
  output ltc_status_t       st,
  output logic              out_valid,
  output logic [1:0]        status,
  output logic [9:0]        slot,
  output logic [10:0]       evicted_count
);

  localparam int SW = $clog2(SLOTS);
  localparam int DEPTH = NUM_TABLES * SLOTS;
  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(SLOTS + 1);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [STAMP_BITS-1:0] stamp_mem [DEPTH];
  logic                  valid_mem [DEPTH];
  logic [OW-1:0]         occ [NUM_TABLES];
  logic [STAMP_BITS-1:0] counter;
  logic [LIMIT_BITS-1:0] limit;

  logic [KEY_BITS-1:0]   cur_key;
  logic [1:0]            cur_t;
  logic [SW:0]           idx;
  logic                  rd_pend;
  logic [SW-1:0]         rd_slot;
  logic [KEY_BITS-1:0]   rd_key;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  rd_valid;
  logic                  found;
  logic [SW-1:0]         found_slot;
  logic [STAMP_BITS-1:0] best;
  logic [CNT_BITS-1:0]   k_left;
  logic [CNT_BITS-1:0]   k_total;
  logic [AW-1:0]         base;
  logic [AW-1:0]         rd_addr;
  logic                  issuing;
  logic                  scanning;
  logic [OW-1:0]         n;
  logic [OW-1:0]         cap;
  logic [OW+11:0]        third_prod;
  logic [OW-1:0]         n_third;
  logic [OW-1:0]         k_calc;
  logic [AW-1:0]         found_addr;
  logic                  clearing;
  logic [AW-1:0]         clr_addr;
  logic                  vld_we;
  logic [AW-1:0]         vld_addr;
  logic                  vld_data;

  assign base = AW'(cur_t) * AW'(SLOTS);
  assign rd_addr = base + AW'(idx[SW-1:0]);
  assign found_addr = base + AW'(found_slot);
  assign scanning = (cmd.op == CMD_SCAN) || (cmd.op == CMD_EVICT_SCAN)
                    || (cmd.op == CMD_FREE_SCAN);
  assign issuing = scanning && (idx < (SW+1)'(SLOTS));
  assign n = occ[cur_t < 2'd3 ? cur_t : 2'd0];
  assign cap = (OW'(limit) < OW'(SLOTS) && limit < 11'(SLOTS)) ? OW'(limit) : OW'(SLOTS);
  assign third_prod = (OW+12)'(n) * (OW+12)'(2731);
  assign n_third = OW'(third_prod >> 13);
  assign k_calc = (n_third + OW'(1) > n) ? n : n_third + OW'(1);

  assign vld_we = clearing || (cmd.op == CMD_INSERT)
                  || ((cmd.op == CMD_EVICT_KILL) && found);
  assign vld_addr = clearing ? clr_addr
                    : ((cmd.op == CMD_INSERT) && !found) ? base : found_addr;
  assign vld_data = !clearing && (cmd.op == CMD_INSERT);

  assign st.scan_done = scanning && !issuing && !rd_pend;
  assign st.hit = found;
  assign st.need_evict = (n >= cap);
  assign st.evict_more = (k_left != '0);
  assign st.invalid_target = (cur_t == 2'd3);
  assign st.clearing = clearing;

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
    rd_valid <= valid_mem[rd_addr];
    if (vld_we) begin
      valid_mem[vld_addr] <= vld_data;
    end
    if (cmd.op == CMD_HIT) begin
      stamp_mem[found_addr] <= counter;
    end else if (cmd.op == CMD_INSERT) begin
      key_mem[found_addr] <= cur_key;
      stamp_mem[found_addr] <= counter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) begin
      cur_key <= key[KEY_BITS-1:0];
      cur_t <= target;
    end
    rd_slot <= idx[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        occ[i] <= '0;
      end
      counter <= '0;
      limit <= LIMIT_RESET;
      out_valid <= 1'b0;
      status <= STATUS_HIT;
      slot <= '0;
      evicted_count <= '0;
      idx <= '0;
      rd_pend <= 1'b0;
      found <= 1'b0;
      found_slot <= '0;
      best <= '0;
      k_left <= '0;
      k_total <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (entry_limit_we) begin
        limit <= entry_limit;
      end
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      rd_pend <= issuing;
      if (issuing) begin
        idx <= idx + 1'b1;
      end
      case (cmd.op)
        CMD_LOAD: begin
          counter <= counter + 1'b1;
          idx <= '0;
          found <= 1'b0;
          k_total <= '0;
          k_left <= '0;
        end
        CMD_INVALID: begin
          out_valid <= 1'b1;
          status <= STATUS_INVALID;
          slot <= '0;
          evicted_count <= '0;
        end
        CMD_SCAN: begin
          if (rd_pend && !found && rd_valid && rd_key == cur_key) begin
            found <= 1'b1;
            found_slot <= rd_slot;
          end
        end
        CMD_SET_K: begin
          k_left <= CNT_BITS'(k_calc);
          k_total <= CNT_BITS'(k_calc);
          idx <= '0;
          found <= 1'b0;
        end
        CMD_EVICT_SCAN: begin
          if (rd_pend && rd_valid && (!found || rd_stamp < best)) begin
            found <= 1'b1;
            found_slot <= rd_slot;
            best <= rd_stamp;
          end
        end
        CMD_EVICT_KILL: begin
          if (found) begin
            if (n != '0) begin
              occ[cur_t] <= n - 1'b1;
            end
          end
          k_left <= k_left - 1'b1;
          idx <= '0;
          found <= 1'b0;
        end
        CMD_FREE_START: begin
          idx <= '0;
          found <= 1'b0;
        end
        CMD_FREE_SCAN: begin
          if (rd_pend && !found && !rd_valid) begin
            found <= 1'b1;
            found_slot <= rd_slot;
          end
        end
        CMD_INSERT: begin
          if (!found) begin
            slot <= '0;
          end else begin
            occ[cur_t] <= n + 1'b1;
            slot <= 10'(found_slot);
          end
          out_valid <= 1'b1;
          status <= STATUS_MISS;
          evicted_count <= k_total;
        end
        CMD_HIT: begin
          out_valid <= 1'b1;
          status <= STATUS_HIT;
          slot <= 10'(found_slot);
          evicted_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/lru_tag_cache_bulk_evict.sv @@
// A hit raises its result beat after one scan of the target table for the key.
// A miss adds a free-slot scan, and when it evicts, one scan and one kill per evicted entry.
// An invalid target raises its result beat straight from the start state, with no scan.
// Throughput: one beat at a time; the next is accepted once the result is taken.
// Reset (rst, synchronous) clears occupancy and counter and sets the limit to 1000;
// then a pass over all 3 * SLOTS entries clears the valid bits while the input stalls.
module lru_tag_cache_bulk_evict
  import ltc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        entry_limit_we,
  input  logic [10:0] entry_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] key,
  input  logic [1:0]  target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [9:0]  slot,
  output logic [10:0] evicted_count
);

  ltc_cmd_t    cmd;
  ltc_status_t st;
  logic        in_fire;
  logic        out_fire;

  assign in_fire = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  ltc_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_valid, .out_fire, .st, .in_stall, .cmd
  );

  ltc_datapath u_dp (
    .clk, .rst, .cmd, .key, .target, .entry_limit_we, .entry_limit, .out_fire,
    .st, .out_valid, .status, .slot, .evicted_count
  );

endmodule

@@ sv/ltc_checker.sv @@
module ltc_checker
  import ltc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [9:0]  slot,
  input logic [10:0] evicted_count
);

  // A new input is never accepted while a result is held by a stalling receiver.
  a_no_accept_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(in_valid && !in_stall))
    else $error("accepted while result held");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_HIT || status == STATUS_INVALID) |-> evicted_count == '0)
    else $error("eviction reported without miss");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(slot)) else $error("result dropped");

endmodule

bind lru_tag_cache_bulk_evict ltc_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .slot,
  .evicted_count
);

@@ bench/lru_tag_cache_bulk_evict_test.sv @@
`timescale 1ns / 1ps

module lru_tag_cache_bulk_evict_test
  import ltc_pkg::*;
();

  localparam longint CYCLE_LIMIT = 60000000;

  typedef struct packed {
    logic [23:0] key;
    logic [1:0]  target;
  } lookup_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [10:0] evicted;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        entry_limit_we;
  logic [10:0] entry_limit;
  logic        in_valid;
  logic        in_stall;
  logic [23:0] key;
  logic [1:0]  target;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [9:0]  slot;
  logic [10:0] evicted_count;

  lru_tag_cache_bulk_evict u_dut (
    .clk(clk), .rst(rst),
    .entry_limit_we(entry_limit_we), .entry_limit(entry_limit),
    .in_valid(in_valid), .in_stall(in_stall), .key(key), .target(target),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot(slot), .evicted_count(evicted_count)
  );

  lookup_t  lookup_q[$];
  outcome_t outcome_q[$];

  logic        tag_valid[3*SLOTS];
  logic [23:0] tag_key[3*SLOTS];
  logic [63:0] tag_stamp[3*SLOTS];
  int          tag_occ[3];
  logic [63:0] access_cnt;
  logic [10:0] limit_shadow;

  int     mismatches;
  int     accepted_in;
  int     accepted_out;
  int     hits_seen;
  int     evictions_seen;
  longint cycles;
  logic   sender_hold;
  int     burst_left;
  int     gap_left;
  int     long_stall_req;
  int     long_stall_left;
  int     stall_mode;
  int     stall_mode_left;

  function automatic void drop_oldest(int base, int t);
    int victim;
    logic [63:0] best;
    victim = -1;
    best = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_valid[base+i] && (victim < 0 || tag_stamp[base+i] < best)) begin
        victim = i;
        best = tag_stamp[base+i];
      end
    end
    if (victim >= 0) begin
      tag_valid[base+victim] = 1'b0;
      if (tag_occ[t] > 0) tag_occ[t]--;
    end
  endfunction

  function automatic outcome_t cache_lookup(lookup_t it);
    outcome_t r;
    int base, n, cap, k, fs;
    r = '0;
    access_cnt = access_cnt + 64'd1;
    if (it.target == 2'd3) begin
      r.status = STATUS_INVALID;
      return r;
    end
    base = int'(it.target) * SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_valid[base+i] && tag_key[base+i] == it.key) begin
        tag_stamp[base+i] = access_cnt;
        r.status = STATUS_HIT;
        r.slot = i[9:0];
        return r;
      end
    end
    n = tag_occ[it.target];
    cap = (int'(limit_shadow) < SLOTS) ? int'(limit_shadow) : SLOTS;
    k = 0;
    if (n >= cap) begin
      k = n / 3 + 1;
      if (k > n) k = n;
      for (int j = 0; j < k; j++) drop_oldest(base, int'(it.target));
    end
    fs = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tag_valid[base+i]) begin
        fs = i;
        break;
      end
    end
    if (fs < 0) fs = 0;
    else tag_occ[it.target]++;
    tag_valid[base+fs] = 1'b1;
    tag_key[base+fs] = it.key;
    tag_stamp[base+fs] = access_cnt;
    r.status = STATUS_MISS;
    r.slot = fs[9:0];
    r.evicted = k[10:0];
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    lookup_t it;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(cache_lookup('{key: key, target: target}));
        accepted_in <= accepted_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (in_valid && burst_left <= 1) begin
          in_valid <= 1'b0;
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else if (gap_left > 0 && !in_valid) begin
          gap_left <= gap_left - 1;
        end else if (lookup_q.size() > 0 && !sender_hold) begin
          it = lookup_q.pop_front();
          in_valid <= 1'b1;
          key <= it.key;
          target <= it.target;
          if (in_valid) burst_left <= burst_left - 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      long_stall_left <= 0;
      stall_mode <= 0;
      stall_mode_left <= 0;
    end else if (long_stall_req > 0 && long_stall_left == 0) begin
      long_stall_left <= long_stall_req;
      long_stall_req <= 0;
      out_stall <= 1'b1;
    end else if (long_stall_left > 0) begin
      long_stall_left <= long_stall_left - 1;
      out_stall <= (long_stall_left > 1);
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(50, 4000);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      accepted_out <= accepted_out + 1;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d slot %0d evicted %0d",
                   status, slot, evicted_count);
      end else begin
        exp_r = outcome_q.pop_front();
        if (status == STATUS_HIT) hits_seen <= hits_seen + 1;
        if (evicted_count != 0) evictions_seen <= evictions_seen + 1;
        if (status !== exp_r.status || slot !== exp_r.slot ||
            evicted_count !== exp_r.evicted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status %0d slot %0d evicted %0d, got %0d %0d %0d",
                     exp_r.status, exp_r.slot, exp_r.evicted,
                     status, slot, evicted_count);
        end
      end
    end
  end

  task automatic push_lookup(logic [23:0] k, logic [1:0] t);
    lookup_q.push_back('{key: k, target: t});
  endtask

  task automatic wait_drained();
    wait (lookup_q.size() == 0 && !in_valid && outcome_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [10:0] v);
    @(posedge clk);
    entry_limit_we <= 1'b1;
    entry_limit <= v;
    @(posedge clk);
    entry_limit_we <= 1'b0;
    limit_shadow = v;
  endtask

  task automatic random_phase(int count, int pool);
    logic [23:0] base_key;
    logic [1:0] t;
    base_key = $urandom_range(0, 24'hFFFFFF - 64);
    for (int i = 0; i < count; i++) begin
      t = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) push_lookup(24'($urandom), t);
      else push_lookup(base_key + 24'($urandom_range(0, pool - 1)), t);
    end
  endtask

  initial begin
    int plan_limit[8] = '{0, 1, 2, 3, 5, 8, 13, 4};
    rst = 1'b1;
    entry_limit_we = 1'b0;
    entry_limit = '0;
    in_valid = 1'b0;
    key = '0;
    target = '0;
    out_stall = 1'b0;
    sender_hold = 1'b0;
    long_stall_req = 0;
    mismatches = 0;
    accepted_in = 0;
    accepted_out = 0;
    hits_seen = 0;
    evictions_seen = 0;
    cycles = 0;
    for (int i = 0; i < 3*SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_key[i] = '0;
      tag_stamp[i] = '0;
    end
    for (int i = 0; i < 3; i++) tag_occ[i] = 0;
    access_cnt = '0;
    limit_shadow = LIMIT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    push_lookup(24'h000000, 2'd3);
    push_lookup(24'hFFFFFF, 2'd3);
    push_lookup(24'h000000, 2'd0);
    push_lookup(24'h000000, 2'd0);
    push_lookup(24'hFFFFFF, 2'd0);
    push_lookup(24'hFFFFFF, 2'd1);
    push_lookup(24'hFFFFFF, 2'd2);
    push_lookup(24'h000000, 2'd2);
    push_lookup(24'hFFFFFF, 2'd1);
    push_lookup(24'h555555, 2'd0);
    push_lookup(24'hAAAAAA, 2'd0);
    push_lookup(24'h000000, 2'd0);
    wait_drained();

    set_limit(11'd1024);
    for (int i = 0; i < 6; i++) push_lookup(24'($urandom), 2'($urandom_range(0, 3)));
    wait_drained();

    set_limit(11'd2047);
    for (int i = 0; i < 6; i++) push_lookup(24'($urandom), 2'($urandom_range(0, 3)));
    wait_drained();

    set_limit(11'd0);
    push_lookup(24'h000123, 2'd1);
    push_lookup(24'h000124, 2'd1);
    push_lookup(24'h000123, 2'd1);
    wait_drained();

    foreach (plan_limit[p]) begin
      set_limit(11'(plan_limit[p]));
      random_phase(125, 3 * plan_limit[p] + 4);
      if (p == 2) begin
        sender_hold = 1'b1;
        wait (outcome_q.size() == 0 && !in_valid);
        long_stall_req = 6000;
        sender_hold = 1'b0;
      end
      if (p == 5) begin
        sender_hold = 1'b1;
        wait (outcome_q.size() == 0 && !in_valid);
        repeat ($urandom_range(10, 200)) @(posedge clk);
        sender_hold = 1'b0;
      end
      wait_drained();
    end

    repeat (SLOTS * 4) @(posedge clk);
    $display("lookups sent %0d, results checked %0d, hits %0d, evicting misses %0d",
             accepted_in, accepted_out, hits_seen, evictions_seen);
    $display("limits covered: reset value, 0 to 5, 8, 13, 1024 and 2047");
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outcome_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
